// ===== hw/rtl/ctb_pkg.sv =====
// ----------------------------------------------------------------------------
// ctb_pkg: shared constants and types for the calorimeter tower binner
// Field widths, image geometry, opcodes and register indexes.
// ----------------------------------------------------------------------------
package ctb_pkg;

  // item field widths
  localparam int OP_W     = 2;
  localparam int ENERGY_W = 16;
  localparam int PHI_W    = 7;
  localparam int ETA_W    = 5;
  localparam int ADDR_W   = 12;
  localparam int ACC_W    = 24;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // detector geometry
  localparam int PHI_COUNT         = 72;
  localparam int ETA_LAST          = 29;
  localparam int ETA_FINE_LIMIT    = 20;
  localparam int ETA_OVERLAP_LIMIT = 17;

  localparam int FULL_DEPTH = 2 * (ETA_LAST - 1) * PHI_COUNT;
  localparam int OVL_DEPTH  = 2 * ETA_OVERLAP_LIMIT * PHI_COUNT;
  localparam int FULL_AW    = $clog2(FULL_DEPTH);
  localparam int OVL_AW     = $clog2(OVL_DEPTH);
  localparam int FROW_W     = $clog2(2 * (ETA_LAST - 1));
  localparam int OROW_W     = $clog2(2 * ETA_OVERLAP_LIMIT);
  localparam int COL_W      = $clog2(PHI_COUNT);

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_ADD_HIT   = 2'd0,
    OP_READ_FULL = 2'd1,
    OP_READ_OVL  = 2'd2
  } op_t;

  // register index = paddr[2]
  typedef enum logic [0:0] {
    REG_ZERO_SUPPRESS = 1'b0
  } reg_idx_t;

endpackage

// ===== hw/rtl/ctb_if.sv =====
// ----------------------------------------------------------------------------
// ctb_if: valid/ready channels of the calorimeter tower binner
// Hit/read command channel and bin result channel.
// ----------------------------------------------------------------------------
interface ctb_in_if;
  logic                          valid;
  logic                          ready;
  logic [ctb_pkg::OP_W-1:0]      opcode;
  logic [ctb_pkg::ENERGY_W-1:0]  hit_energy;
  logic [ctb_pkg::PHI_W-1:0]     phi_index;
  logic [ctb_pkg::ETA_W-1:0]     eta_abs_index;
  logic                          side_positive;
  logic [ctb_pkg::ADDR_W-1:0]    bin_address;

  modport source (output valid, opcode, hit_energy, phi_index, eta_abs_index,
                  side_positive, bin_address, input ready);
  modport sink   (input valid, opcode, hit_energy, phi_index, eta_abs_index,
                  side_positive, bin_address, output ready);
endinterface

interface ctb_out_if;
  logic                       valid;
  logic                       ready;
  logic [ctb_pkg::ACC_W-1:0]  bin_energy;
  logic [ctb_pkg::ADDR_W-1:0] bin_echo;

  modport source (output valid, bin_energy, bin_echo, input ready);
  modport sink   (input valid, bin_energy, bin_echo, output ready);
endinterface

// ===== hw/rtl/calorimeter_tower_binner.sv =====
// ----------------------------------------------------------------------------
// calorimeter_tower_binner: hit accumulation into tower images
// Flow: a command transfer is followed by a memory read and a write back
//   before the next is taken, both twice for a coarse hit split over two phi
//   bins; a dropped hit or unused opcode is taken with no memory access.
// Rate is set by the read-modify-write sequence on the image memories.
// Reset: a clearing pass over all FULL_DEPTH (4032) addresses zeroes both images;
//   no command is taken meanwhile, configuration writes are.
// ----------------------------------------------------------------------------
module calorimeter_tower_binner (
  input  logic                         clk,
  input  logic                         rst_n,
  ctb_in_if.sink                       in_ch,
  ctb_out_if.source                    out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [ctb_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [ctb_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [ctb_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import ctb_pkg::*;

  localparam int PHW1 = PHI_W + 8;
  localparam int ETW1 = ETA_W + 8;
  localparam int ADW1 = ADDR_W + 8;
  localparam int AMT_W = ENERGY_W + 1;

  // Sequencer: CLEAR after reset, then IDLE -> RD -> WR per memory access.
  // A coarse hit with a second phi bin loops WR -> RD once more.
  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_RD    = 4'b0100,
    S_WR    = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // --------------------------------------------------------------------------
  // Configuration register (APB, zero wait state)
  // --------------------------------------------------------------------------
  logic [ENERGY_W-1:0] zsl_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_ZERO_SUPPRESS) ? CFG_DW'(zsl_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zsl_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_ZERO_SUPPRESS) begin
      zsl_r <= cfg_pwdata[ENERGY_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Command decode (combinational, on the input payload)
  // --------------------------------------------------------------------------
  logic [PHW1-1:0]   csum;
  logic [COL_W-1:0]  col;
  logic [ETA_W-1:0]  folded;
  logic [FROW_W-1:0] frow;
  logic [OROW_W-1:0] orow;
  logic              phi_ok, eta_ok, hit_ok, coarse;
  logic              hit_ovl, hit_second;
  logic [AMT_W-1:0]  amount;
  logic [FULL_AW-1:0] hit_faddr;
  logic [OVL_AW-1:0]  hit_oaddr;
  logic              rd_full_ok, rd_ovl_ok;
  logic              dec_go, dec_full_en, dec_ovl_en, dec_second;
  logic [FULL_AW-1:0] dec_faddr;
  logic [OVL_AW-1:0]  dec_oaddr;
  logic              in_xfer;

  always_comb begin
    // phi shifted up by two, wrapping into 1..PHI_COUNT, then zero-based
    csum = PHW1'(in_ch.phi_index) + PHW1'(2);
    if (csum > PHW1'(PHI_COUNT)) begin
      col = COL_W'(csum - PHW1'(PHI_COUNT) - PHW1'(1));
    end else begin
      col = COL_W'(csum - PHW1'(1));
    end

    // last eta ring folds into its neighbor
    folded = (ETW1'(in_ch.eta_abs_index) == ETW1'(ETA_LAST)) ?
             ETA_W'(ETA_LAST - 1) : in_ch.eta_abs_index;

    // rows: positive side above the center line, negative side below
    if (in_ch.side_positive) begin
      frow = FROW_W'(folded) + FROW_W'(ETA_LAST - 2);
      orow = OROW_W'(folded) + OROW_W'(ETA_OVERLAP_LIMIT - 1);
    end else begin
      frow = FROW_W'(ETA_LAST - 1) - FROW_W'(folded);
      orow = OROW_W'(ETA_OVERLAP_LIMIT) - OROW_W'(folded);
    end

    phi_ok = (in_ch.phi_index != '0) && (PHW1'(in_ch.phi_index) <= PHW1'(PHI_COUNT));
    eta_ok = (in_ch.eta_abs_index != '0) &&
             (ETW1'(in_ch.eta_abs_index) <= ETW1'(ETA_LAST));
    hit_ok = phi_ok && eta_ok && (in_ch.hit_energy > zsl_r);
    coarse = ETW1'(in_ch.eta_abs_index) > ETW1'(ETA_FINE_LIMIT);

    // overlap image only for fine hits inside the barrel-overlap range
    hit_ovl    = hit_ok && !coarse &&
                 (ETW1'(in_ch.eta_abs_index) <= ETW1'(ETA_OVERLAP_LIMIT));
    // second half of a coarse hit, dropped past the last phi column
    hit_second = coarse && (col != COL_W'(PHI_COUNT - 1));
    // half-unit energies: coarse halves carry E, fine hits 2E
    amount     = coarse ? {1'b0, in_ch.hit_energy} : {in_ch.hit_energy, 1'b0};

    hit_faddr = FULL_AW'(frow) * FULL_AW'(PHI_COUNT) + FULL_AW'(col);
    hit_oaddr = OVL_AW'(orow) * OVL_AW'(PHI_COUNT) + OVL_AW'(col);

    rd_full_ok = ADW1'(in_ch.bin_address) < ADW1'(FULL_DEPTH);
    rd_ovl_ok  = ADW1'(in_ch.bin_address) < ADW1'(OVL_DEPTH);

    dec_go      = 1'b0;
    dec_full_en = 1'b0;
    dec_ovl_en  = 1'b0;
    dec_second  = 1'b0;
    dec_faddr   = hit_faddr;
    dec_oaddr   = hit_oaddr;
    case (in_ch.opcode)
      OP_ADD_HIT: begin
        dec_go      = hit_ok;
        dec_full_en = hit_ok;
        dec_ovl_en  = hit_ovl;
        dec_second  = hit_second;
      end
      OP_READ_FULL: begin
        dec_go      = 1'b1;
        dec_full_en = rd_full_ok;
        dec_faddr   = in_ch.bin_address[FULL_AW-1:0];
      end
      OP_READ_OVL: begin
        dec_go     = 1'b1;
        dec_ovl_en = rd_ovl_ok;
        dec_oaddr  = in_ch.bin_address[OVL_AW-1:0];
      end
      default: begin
        dec_go = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // --------------------------------------------------------------------------
  // Item registers
  // --------------------------------------------------------------------------
  op_t                op_r;
  logic [AMT_W-1:0]   amount_r;
  logic [FULL_AW-1:0] faddr_r;
  logic [OVL_AW-1:0]  oaddr_r;
  logic               full_en_r, ovl_en_r, second_en_r, second_r;
  logic [ADDR_W-1:0]  echo_r;

  // --------------------------------------------------------------------------
  // Image memories, synchronous registered read
  // --------------------------------------------------------------------------
  logic [ACC_W-1:0] full_mem [FULL_DEPTH];
  logic [ACC_W-1:0] ovl_mem  [OVL_DEPTH];
  logic [ACC_W-1:0] full_rd_r, ovl_rd_r;

  logic [FULL_AW-1:0] clr_idx_r;
  logic               clearing;
  logic               full_re, ovl_re, full_we, ovl_we;
  logic [FULL_AW-1:0] full_waddr;
  logic [OVL_AW-1:0]  ovl_waddr;
  logic [ACC_W-1:0]   full_wdata, ovl_wdata;

  // write-back side
  logic               wr_is_read, wr_stall, wr_fire, take_second;
  logic [ACC_W:0]     full_sum, ovl_sum;
  logic [ACC_W-1:0]   full_val;

  assign clearing = (state_r == S_CLEAR);
  assign full_re  = (state_r == S_RD) && full_en_r;
  assign ovl_re   = (state_r == S_RD) && ovl_en_r;

  // A read result waits in WR until the output register is free; the
  // memory data registers hold because no new read is issued meanwhile.
  assign wr_is_read  = (op_r != OP_ADD_HIT);
  assign wr_stall    = wr_is_read && out_ch.valid && !out_ch.ready;
  assign wr_fire     = (state_r == S_WR) && !wr_stall;
  assign take_second = wr_fire && (op_r == OP_ADD_HIT) && second_en_r && !second_r;

  always_comb begin
    full_sum = (ACC_W + 1)'(full_rd_r) + (ACC_W + 1)'(amount_r);
    ovl_sum  = (ACC_W + 1)'(ovl_rd_r) + (ACC_W + 1)'(amount_r);

    if (clearing) begin
      full_wdata = '0;
      ovl_wdata  = '0;
    end else if (op_r == OP_ADD_HIT) begin
      // saturating accumulate
      full_wdata = full_sum[ACC_W] ? ACC_MAX : full_sum[ACC_W-1:0];
      ovl_wdata  = ovl_sum[ACC_W] ? ACC_MAX : ovl_sum[ACC_W-1:0];
    end else begin
      // read and clear
      full_wdata = '0;
      ovl_wdata  = '0;
    end

    full_waddr = clearing ? clr_idx_r : faddr_r;
    ovl_waddr  = clearing ? clr_idx_r[OVL_AW-1:0] : oaddr_r;
    full_we    = clearing || (wr_fire && full_en_r);
    ovl_we     = (clearing && ((FULL_AW + 1)'(clr_idx_r) < (FULL_AW + 1)'(OVL_DEPTH))) ||
                 (wr_fire && ovl_en_r);

    // full-image reads are suppressed at or below twice the threshold
    full_val = (full_rd_r <= ACC_W'({zsl_r, 1'b0})) ? '0 : full_rd_r;
  end

  always_ff @(posedge clk) begin
    if (full_we) full_mem[full_waddr] <= full_wdata;
    if (full_re) full_rd_r <= full_mem[faddr_r];
  end

  always_ff @(posedge clk) begin
    if (ovl_we) ovl_mem[ovl_waddr] <= ovl_wdata;
    if (ovl_re) ovl_rd_r <= ovl_mem[oaddr_r];
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_idx_r == FULL_AW'(FULL_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer && dec_go) state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_WR;
      end
      S_WR: begin
        if (take_second) begin
          state_nxt = S_RD;
        end else if (wr_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_idx_r <= '0;
      second_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing) clr_idx_r <= clr_idx_r + FULL_AW'(1);
      if (in_xfer) begin
        second_r <= 1'b0;
      end else if (take_second) begin
        second_r <= 1'b1;
      end
    end
  end

  // item payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r        <= op_t'(in_ch.opcode);
      amount_r    <= amount;
      faddr_r     <= dec_faddr;
      oaddr_r     <= dec_oaddr;
      full_en_r   <= dec_full_en;
      ovl_en_r    <= dec_ovl_en;
      second_en_r <= dec_second;
      echo_r      <= in_ch.bin_address;
    end else if (take_second) begin
      // neighbor phi bin of the same row
      faddr_r <= faddr_r + FULL_AW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Output register: a finished result waits here while the next command
  // is taken.
  // --------------------------------------------------------------------------
  logic             out_valid_r;
  logic [ACC_W-1:0] out_energy_r;
  logic [ADDR_W-1:0] out_echo_r;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.bin_energy = out_energy_r;
  assign out_ch.bin_echo   = out_echo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wr_fire && wr_is_read) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire && wr_is_read) begin
      out_echo_r <= echo_r;
      if (op_r == OP_READ_FULL) begin
        out_energy_r <= full_en_r ? full_val : '0;
      end else begin
        out_energy_r <= ovl_en_r ? ovl_rd_r : '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_valid_r)
    else $error("result pending during clearing pass");

  a_rd_then_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |=> (state_r == S_WR))
    else $error("memory read not followed by write-back");

  a_second_pass_hit: assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> (op_r == OP_ADD_HIT) && second_en_r && !ovl_en_r)
    else $error("second phi pass on an item without a second bin");

  a_stall_holds_data: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_WR) && wr_stall) |=> (state_r == S_WR) && $stable(full_rd_r) &&
      $stable(ovl_rd_r))
    else $error("read data lost while waiting for the output register");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for calorimeter_tower_binner
// Drives hit and bin-read commands over the valid/ready input channel and
// sets the zero-suppress level over the APB-style port between phases. A
// tower-image scoreboard tracks both images and checks every bin read that
// comes back, field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ctb_pkg::*;

  // run control
  localparam int CYCLE_LIMIT   = 300000;  // clearing pass + slowest legal run, many times over
  localparam int SETTLE_CYCLES = 12;      // covers the coarse write-back and the read latency
  localparam int ENERGY_TOP    = (1 << ENERGY_W) - 1;

  // opcode the block must ignore
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // saturation burst kinds for a random phase
  localparam int NO_BURST     = 0;
  localparam int FINE_BURST   = 1;
  localparam int COARSE_BURST = 2;

  typedef struct {
    logic [OP_W-1:0]     opcode;
    logic [ENERGY_W-1:0] hit_energy;
    logic [PHI_W-1:0]    phi_index;
    logic [ETA_W-1:0]    eta_abs_index;
    logic                side_positive;
    logic [ADDR_W-1:0]   bin_address;
  } bin_cmd_t;

  typedef struct {
    logic [ACC_W-1:0]  energy;
    logic [ADDR_W-1:0] echo;
  } bin_result_t;

  // --------------------------------------------------------------------------
  // Tower-image scoreboard: own copy of both images and the threshold.
  // note_command() updates the images for every accepted command and queues
  // the bin value a read must return; check_bin() pops and compares.
  // --------------------------------------------------------------------------
  class tower_scoreboard;
    logic [ACC_W-1:0]    full_img [FULL_DEPTH];
    logic [ACC_W-1:0]    ovl_img  [OVL_DEPTH];
    logic [ENERGY_W-1:0] zs_level;
    bin_result_t         expected_bins [$];
    int                  errors;

    function new();
      foreach (full_img[i]) full_img[i] = '0;
      foreach (ovl_img[i]) ovl_img[i] = '0;
      zs_level = '0;
      errors   = 0;
    endfunction

    function void set_level(logic [ENERGY_W-1:0] v);
      zs_level = v;
    endfunction

    function int level();
      return int'(zs_level);
    endfunction

    function int pending();
      return expected_bins.size();
    endfunction

    // phi shifted up by two, wrapped into 1..PHI_COUNT, then zero based
    function int tower_col(int phi);
      int c;
      c = phi + 2;
      if (c > PHI_COUNT) c -= PHI_COUNT;
      return c - 1;
    endfunction

    // signed eta after folding the last ring onto its neighbor
    function int signed_eta(int eta, bit pos);
      int f;
      f = (eta == ETA_LAST) ? ETA_LAST - 1 : eta;
      return pos ? f - 1 : -f;
    endfunction

    function int full_bin(int phi, int eta, bit pos);
      return (signed_eta(eta, pos) + ETA_LAST - 1) * PHI_COUNT + tower_col(phi);
    endfunction

    function int ovl_bin(int phi, int eta, bit pos);
      return (signed_eta(eta, pos) + ETA_OVERLAP_LIMIT) * PHI_COUNT + tower_col(phi);
    endfunction

    function logic [ACC_W-1:0] sat_add(logic [ACC_W-1:0] acc, int amount);
      int s;
      s = int'(acc) + amount;
      return (s > int'(ACC_MAX)) ? ACC_MAX : ACC_W'(s);
    endfunction

    function void add_hit(bin_cmd_t c);
      int e;
      int phi;
      int eta;
      int col;
      int idx;
      e   = int'(c.hit_energy);
      phi = int'(c.phi_index);
      eta = int'(c.eta_abs_index);
      if (e <= int'(zs_level)) return;
      if (phi < 1 || phi > PHI_COUNT) return;
      if (eta < 1 || eta > ETA_LAST) return;
      col = tower_col(phi);
      idx = full_bin(phi, eta, c.side_positive);
      if (eta > ETA_FINE_LIMIT) begin
        // coarse: half energy into two phi bins, the second lost past the edge
        full_img[idx] = sat_add(full_img[idx], e);
        if (col + 1 < PHI_COUNT) full_img[idx + 1] = sat_add(full_img[idx + 1], e);
        return;
      end
      full_img[idx] = sat_add(full_img[idx], 2 * e);
      if (eta > ETA_OVERLAP_LIMIT) return;
      idx = ovl_bin(phi, eta, c.side_positive);
      ovl_img[idx] = sat_add(ovl_img[idx], 2 * e);
    endfunction

    function void note_command(bin_cmd_t c);
      bin_result_t r;
      int a;
      a        = int'(c.bin_address);
      r.echo   = c.bin_address;
      r.energy = '0;
      case (c.opcode)
        OP_ADD_HIT: add_hit(c);
        OP_READ_FULL: begin
          if (a < FULL_DEPTH) begin
            r.energy    = full_img[a];
            full_img[a] = '0;
            if (int'(r.energy) <= 2 * int'(zs_level)) r.energy = '0;
          end
          expected_bins.push_back(r);
        end
        OP_READ_OVL: begin
          if (a < OVL_DEPTH) begin
            r.energy   = ovl_img[a];
            ovl_img[a] = '0;
          end
          expected_bins.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_bin(logic [ACC_W-1:0] energy, logic [ADDR_W-1:0] echo);
      bin_result_t r;
      if (expected_bins.size() == 0) begin
        $error("unexpected bin result: bin_energy %0d, bin_echo %0d", energy, echo);
        errors++;
        return;
      end
      r = expected_bins.pop_front();
      if (energy !== r.energy) begin
        $error("bin_energy mismatch: expected %0d, actual %0d", r.energy, energy);
        errors++;
      end
      if (echo !== r.echo) begin
        $error("bin_echo mismatch: expected %0d, actual %0d", r.echo, echo);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ctb_in_if  in_ch ();
  ctb_out_if out_ch ();

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  calorimeter_tower_binner uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  tower_scoreboard sb = new();

  bit idle_on = 1'b1;  // random bursts of idling on both channels
  int n_sent  = 0;     // accepted command transfers
  int cycle_count = 0;

  // --------------------------------------------------------------------------
  // Result side: ready drops in random bursts while idling is on.
  // Driven at the falling edge, like every other input.
  // --------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = int'($urandom_range(0, 4));
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // result transfers are checked on the rising edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_bin(out_ch.bin_energy, out_ch.bin_echo);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Command driver
  // --------------------------------------------------------------------------

  // all fields random; callers overwrite the ones that matter
  function automatic bin_cmd_t random_cmd();
    bin_cmd_t c;
    c.opcode        = OP_W'($urandom);
    c.hit_energy    = ENERGY_W'($urandom);
    c.phi_index     = PHI_W'($urandom);
    c.eta_abs_index = ETA_W'($urandom);
    c.side_positive = 1'($urandom);
    c.bin_address   = ADDR_W'($urandom);
    return c;
  endfunction

  // one command transfer; valid stays high afterwards unless a gap or drain follows
  task automatic send_cmd(input bin_cmd_t c);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = int'($urandom_range(1, 5));
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= c.opcode;
    in_ch.hit_energy    <= c.hit_energy;
    in_ch.phi_index     <= c.phi_index;
    in_ch.eta_abs_index <= c.eta_abs_index;
    in_ch.side_positive <= c.side_positive;
    in_ch.bin_address   <= c.bin_address;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_command(c);
    n_sent++;
  endtask

  task automatic send_hit(input int e, input int phi, input int eta, input bit pos);
    bin_cmd_t c;
    c               = random_cmd();
    c.opcode        = OP_ADD_HIT;
    c.hit_energy    = ENERGY_W'(e);
    c.phi_index     = PHI_W'(phi);
    c.eta_abs_index = ETA_W'(eta);
    c.side_positive = pos;
    send_cmd(c);
  endtask

  task automatic send_read(input logic [OP_W-1:0] op, input int addr);
    bin_cmd_t c;
    c             = random_cmd();
    c.opcode      = op;
    c.bin_address = ADDR_W'(addr);
    send_cmd(c);
  endtask

  // stop sending, wait for every queued bin read; optionally let the block go quiet
  task automatic drain_results(input bit settle);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup then access, register taken when pready is seen high
  task automatic set_zero_suppress(input logic [ENERGY_W-1:0] lvl);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_ZERO_SUPPRESS, 2'b00};
    cfg_pwdata  <= CFG_DW'(lvl);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_level(lvl);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // energies clustered around the threshold and the top of the range
  function automatic int pick_energy();
    int thr;
    int v;
    thr = sb.level();
    case ($urandom_range(0, 3))
      0:       v = int'($urandom_range(0, ENERGY_TOP));
      1:       v = thr + int'($urandom_range(0, 3));
      2:       v = thr - int'($urandom_range(0, 3));
      default: v = ENERGY_TOP - int'($urandom_range(0, 3));
    endcase
    if (v > ENERGY_TOP) v = ENERGY_TOP;
    if (v < 0) v = 0;
    return v;
  endfunction

  // a few hits, often stacked on one tower, then reads of the touched bins
  task automatic hit_cluster();
    int k;
    int phi;
    int eta;
    bit pos;
    int idx;
    int ph[$];
    int et[$];
    bit ps[$];
    k = int'($urandom_range(1, 6));
    for (int i = 0; i < k; i++) begin
      if (i == 0 || $urandom_range(0, 2) != 0) begin
        phi = int'($urandom_range(1, PHI_COUNT));
        eta = int'($urandom_range(1, ETA_LAST));
        pos = 1'($urandom);
      end
      send_hit(pick_energy(), phi, eta, pos);
      ph.push_back(phi);
      et.push_back(eta);
      ps.push_back(pos);
    end
    for (int i = 0; i < k; i++) begin
      // some bins are left to accumulate into later reads
      if ($urandom_range(0, 6) != 0) begin
        idx = sb.full_bin(ph[i], et[i], ps[i]);
        send_read(OP_READ_FULL, idx);
        if (et[i] <= ETA_OVERLAP_LIMIT && $urandom_range(0, 1) == 1)
          send_read(OP_READ_OVL, sb.ovl_bin(ph[i], et[i], ps[i]));
        if (et[i] > ETA_FINE_LIMIT && $urandom_range(0, 1) == 1)
          send_read(OP_READ_FULL, idx + 1);
      end
    end
  endtask

  task automatic stray_read();
    if ($urandom_range(0, 1) == 1) send_read(OP_READ_FULL, int'($urandom_range(0, FULL_DEPTH - 1)));
    else send_read(OP_READ_OVL, int'($urandom_range(0, OVL_DEPTH - 1)));
  endtask

  // ignored opcodes, out-of-range hit indices, reads past the image ends
  task automatic noise_item();
    bin_cmd_t c;
    c = random_cmd();
    case ($urandom_range(0, 5))
      0: c.opcode = OP_UNUSED;
      1: begin
        c.opcode    = OP_ADD_HIT;
        c.phi_index = ($urandom_range(0, 1) == 1) ? '0 : PHI_W'($urandom_range(PHI_COUNT + 1, 127));
      end
      2: begin
        c.opcode        = OP_ADD_HIT;
        c.eta_abs_index = ($urandom_range(0, 1) == 1) ? '0 : ETA_W'($urandom_range(ETA_LAST + 1, 31));
      end
      3: begin
        c.opcode      = OP_READ_FULL;
        c.bin_address = ADDR_W'($urandom_range(FULL_DEPTH, 4095));
      end
      4: begin
        c.opcode      = OP_READ_OVL;
        c.bin_address = ADDR_W'($urandom_range(OVL_DEPTH, 4095));
      end
      default: c.opcode = ($urandom_range(0, 1) == 1) ? OP_READ_FULL : OP_READ_OVL;
    endcase
    send_cmd(c);
  endtask

  // hammer one tower with near-max hits until it clips, then read it back
  task automatic saturate_bin(input bit coarse);
    int phi;
    int eta;
    int n;
    int idx;
    bit pos;
    phi = int'($urandom_range(1, PHI_COUNT));
    eta = coarse ? int'($urandom_range(ETA_FINE_LIMIT + 1, ETA_LAST))
                 : int'($urandom_range(1, ETA_OVERLAP_LIMIT));
    pos = 1'($urandom);
    n   = coarse ? 260 : 140;
    repeat (n) send_hit(ENERGY_TOP - int'($urandom_range(0, 15)), phi, eta, pos);
    idx = sb.full_bin(phi, eta, pos);
    send_read(OP_READ_FULL, idx);
    if (coarse) send_read(OP_READ_FULL, idx + 1);
    else send_read(OP_READ_OVL, sb.ovl_bin(phi, eta, pos));
  endtask

  // mostly well-formed hit/read clusters; halfway the sender holds off until drained
  task automatic run_phase(input int n, input int burst);
    int start;
    int pick;
    bit held;
    if (burst == FINE_BURST) saturate_bin(1'b0);
    else if (burst == COARSE_BURST) saturate_bin(1'b1);
    start = n_sent;
    held  = 1'b0;
    while (n_sent - start < n) begin
      if (!held && n_sent - start >= n / 2) begin
        drain_results(1'b0);
        held = 1'b1;
      end
      pick = int'($urandom_range(0, 99));
      if (pick < 70) hit_cluster();
      else if (pick < 85) stray_read();
      else noise_item();
    end
  endtask

  // level 0 after reset: corners of the mapping and the address space
  task automatic directed_checks();
    bin_cmd_t c;
    send_hit(ENERGY_TOP, PHI_COUNT, 1, 1'b1);                  // phi wraps to column 1
    send_hit(1, PHI_COUNT - 1, ETA_OVERLAP_LIMIT, 1'b0);       // wraps to column 0
    send_hit(ENERGY_TOP, PHI_COUNT - 2, ETA_FINE_LIMIT + 1, 1'b0);  // coarse, last column
    send_hit(3, 1, ETA_LAST, 1'b1);                            // last ring folded
    send_hit(0, 5, 3, 1'b1);                                   // at threshold: dropped
    send_hit(9, 10, ETA_OVERLAP_LIMIT + 1, 1'b1);              // fine, full image only
    send_hit(7, 30, 5, 1'b0);                                  // left for the threshold phase
    send_hit(100, 0, 4, 1'b1);                                 // bad phi
    send_hit(100, 8, 0, 1'b0);                                 // bad eta, low
    send_hit(100, 8, 31, 1'b1);                                // bad eta, high
    c        = random_cmd();
    c.opcode = OP_UNUSED;
    send_cmd(c);
    send_read(OP_READ_FULL, sb.full_bin(PHI_COUNT, 1, 1'b1));
    send_read(OP_READ_OVL, sb.ovl_bin(PHI_COUNT, 1, 1'b1));
    send_read(OP_READ_FULL, sb.full_bin(PHI_COUNT - 1, ETA_OVERLAP_LIMIT, 1'b0));
    send_read(OP_READ_OVL, sb.ovl_bin(PHI_COUNT - 1, ETA_OVERLAP_LIMIT, 1'b0));
    send_read(OP_READ_FULL, sb.full_bin(PHI_COUNT - 2, ETA_FINE_LIMIT + 1, 1'b0));
    // next address is the following row's column 0: must stay empty
    send_read(OP_READ_FULL, sb.full_bin(PHI_COUNT - 2, ETA_FINE_LIMIT + 1, 1'b0) + 1);
    send_read(OP_READ_FULL, sb.full_bin(1, ETA_LAST, 1'b1));
    send_read(OP_READ_FULL, sb.full_bin(1, ETA_LAST, 1'b1) + 1);
    send_read(OP_READ_FULL, sb.full_bin(5, 3, 1'b1));
    send_read(OP_READ_FULL, sb.full_bin(10, ETA_OVERLAP_LIMIT + 1, 1'b1));
    send_read(OP_READ_FULL, 0);
    send_read(OP_READ_FULL, FULL_DEPTH - 1);
    send_read(OP_READ_FULL, FULL_DEPTH);                       // past the end
    send_read(OP_READ_OVL, OVL_DEPTH);                         // past the end
  endtask

  // level 1000: the threshold applies to the summed full bin, not to overlap
  task automatic threshold_checks();
    int idx;
    send_read(OP_READ_FULL, sb.full_bin(30, 5, 1'b0));         // 14 half units: suppressed
    send_read(OP_READ_OVL, sb.ovl_bin(30, 5, 1'b0));           // 14, no threshold
    send_hit(1001, 10, 22, 1'b0);                              // coarse half: 1001 <= 2000
    send_read(OP_READ_FULL, sb.full_bin(10, 22, 1'b0));
    send_hit(1001, 20, 25, 1'b1);
    send_hit(1001, 20, 25, 1'b1);                              // sum 2002 clears the level
    idx = sb.full_bin(20, 25, 1'b1);
    send_read(OP_READ_FULL, idx);
    send_read(OP_READ_FULL, idx + 1);
    send_hit(1000, 40, 8, 1'b1);                               // at level: dropped
    send_hit(1001, 40, 8, 1'b1);
    send_read(OP_READ_FULL, sb.full_bin(40, 8, 1'b1));
    send_read(OP_READ_OVL, sb.ovl_bin(40, 8, 1'b1));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = '0;
    in_ch.hit_energy    = '0;
    in_ch.phi_index     = '0;
    in_ch.eta_abs_index = '0;
    in_ch.side_positive = 1'b0;
    in_ch.bin_address   = '0;
    cfg_psel            = 1'b0;
    cfg_penable         = 1'b0;
    cfg_pwrite          = 1'b0;
    cfg_paddr           = '0;
    cfg_pwdata          = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // the block clears both images first; commands wait on ready
    directed_checks();

    drain_results(1'b1);
    set_zero_suppress(16'd1000);
    threshold_checks();

    drain_results(1'b1);
    set_zero_suppress(ENERGY_W'($urandom_range(1, 4000)));
    run_phase(300, FINE_BURST);

    // top level: every hit is dropped, reads still clear
    drain_results(1'b1);
    set_zero_suppress(ENERGY_W'(ENERGY_TOP));
    run_phase(100, NO_BURST);

    drain_results(1'b1);
    set_zero_suppress(ENERGY_W'($urandom_range(0, 300)));
    run_phase(250, COARSE_BURST);

    drain_results(1'b1);
    set_zero_suppress(ENERGY_W'($urandom_range(20000, 65000)));
    run_phase(80, NO_BURST);

    // last stretch at full rate, no idling on either side
    drain_results(1'b1);
    idle_on = 1'b0;
    set_zero_suppress('0);
    run_phase(150, NO_BURST);

    drain_results(1'b1);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ctb_pkg.sv
hw/rtl/ctb_if.sv
hw/rtl/calorimeter_tower_binner.sv
tb/sv/tb.sv
